>>> hdl/sps_pkg.sv
// package with constants shared by the serial protocol sniffer
package sps_pkg;

    localparam int unsigned SampleSizeDefault = 64;
    localparam int unsigned MinBurst          = 4;

    localparam int unsigned ClassWidth  = 3;
    localparam int unsigned SampleWidth = 7;

    localparam logic [7:0] PairFirst  = 8'h94;
    localparam logic [7:0] PairSecond = 8'hC3;
    localparam logic [7:0] EndMark    = 8'hC0;
    localparam logic [7:0] PrintLow   = 8'h20;
    localparam logic [7:0] PrintHigh  = 8'h7E;
    localparam logic [7:0] CharLf     = 8'h0A;
    localparam logic [7:0] CharCr     = 8'h0D;
    localparam logic [7:0] CharTab    = 8'h09;
    localparam logic [7:0] CharDollar = 8'h24;

    localparam logic [ClassWidth-1:0] ClassPair   = 3'd0;
    localparam logic [ClassWidth-1:0] ClassEndMrk = 3'd1;
    localparam logic [ClassWidth-1:0] ClassGps    = 3'd2;
    localparam logic [ClassWidth-1:0] ClassModem  = 3'd3;
    localparam logic [ClassWidth-1:0] ClassText   = 3'd4;
    localparam logic [ClassWidth-1:0] ClassBinary = 3'd5;

    localparam logic ReqData    = 1'b0;
    localparam logic ReqRestart = 1'b1;

endpackage

>>> hdl/sps_in_if.sv
// input channel carrying received bytes and restart requests
interface sps_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;
    logic       burst_end;

    modport source (output valid, output req_type, output data_byte, output burst_end,
                    input ready);
    modport sink   (input valid, input req_type, input data_byte, input burst_end,
                    output ready);
endinterface

>>> hdl/sps_out_if.sv
// output channel carrying the protocol decision
interface sps_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] protocol_class;
    logic       hex_display;
    logic [6:0] sample_count;

    modport source (output valid, output protocol_class, output hex_display,
                    output sample_count, input ready);
    modport sink   (input valid, input protocol_class, input hex_display,
                    input sample_count, output ready);
endinterface

>>> hdl/serial_protocol_sniffer_core.sv
// serial protocol sniffer: classifies the first bytes of a stream
// an accepted item is held in the input register, then updates the flags and, on a decision, the result register
// throughput: one item per cycle while no result waits in the output register
// a result waiting in the output register stalls the input register
// reset clears all flags and counters and leaves both channels empty
module serial_protocol_sniffer_core #(
    parameter int unsigned SAMPLE_SIZE = sps_pkg::SampleSizeDefault
) (
    input  logic      clk,
    input  logic      rst_n,
    sps_in_if.sink    rx,
    sps_out_if.source result
);
    import sps_pkg::*;

    localparam int unsigned CW = $clog2(SAMPLE_SIZE + 1);
    localparam logic [CW-1:0] SampleLimit = CW'(SAMPLE_SIZE);
    localparam logic [CW-1:0] BurstLimit  = CW'(MinBurst);

    logic       in_valid_reg;
    logic       in_req_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [CW-1:0] print_count_reg, print_count_next;
    logic [7:0]    prev_reg, prev_next;
    logic [7:0]    prev2_reg, prev2_next;
    logic          first_end_reg, first_end_next;
    logic          pair_reg, pair_next;
    logic          framing_reg, framing_next;
    logic          gps_reg, gps_next;
    logic          modem_reg, modem_next;
    logic          decided_reg, decided_next;

    logic                  out_valid_reg, out_valid_next;
    logic [ClassWidth-1:0] class_reg, class_next;
    logic                  hex_reg, hex_next;
    logic [SampleWidth-1:0] count_out_reg, count_out_next;

    logic          advance;
    logic          fire;
    logic          printable;
    logic          at_match, ok_match, gps_match;
    logic [CW+1:0] print_x4, count_x3;
    logic [CW+6:0] count_wide;

    assign advance  = in_valid_reg && (!out_valid_reg || result.ready);
    assign rx.ready = !in_valid_reg || advance;

    assign printable = (in_byte_reg >= PrintLow && in_byte_reg <= PrintHigh)
                       || in_byte_reg == CharLf || in_byte_reg == CharCr
                       || in_byte_reg == CharTab;
    assign at_match  = (prev_reg == "A" || prev_reg == "a")
                       && (in_byte_reg == "T" || in_byte_reg == "t");
    assign ok_match  = prev_reg == "O" && in_byte_reg == "K";
    assign gps_match = (prev_reg == "G" && (in_byte_reg == "P" || in_byte_reg == "N"
                       || in_byte_reg == "L" || in_byte_reg == "A"))
                       || (prev_reg == "B" && in_byte_reg == "D");

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        print_count_next = print_count_reg;
        prev_next        = prev_reg;
        prev2_next       = prev2_reg;
        first_end_next   = first_end_reg;
        pair_next        = pair_reg;
        framing_next     = framing_reg;
        gps_next         = gps_reg;
        modem_next       = modem_reg;
        decided_next     = decided_reg;
        fire             = 1'b0;

        if (advance)
        begin
            if (in_req_reg == ReqRestart)
            begin
                byte_count_next  = '0;
                print_count_next = '0;
                prev_next        = '0;
                prev2_next       = '0;
                first_end_next   = 1'b0;
                pair_next        = 1'b0;
                framing_next     = 1'b0;
                gps_next         = 1'b0;
                modem_next       = 1'b0;
                decided_next     = 1'b0;
            end
            else if (!decided_reg)
            begin
                if (byte_count_reg == '0)
                begin
                    first_end_next = (in_byte_reg == EndMark);
                end
                else
                begin
                    if (first_end_reg && in_byte_reg == EndMark)
                        framing_next = 1'b1;
                    if (prev_reg == PairFirst && in_byte_reg == PairSecond)
                        pair_next = 1'b1;
                    if ((byte_count_reg == CW'(1) || prev2_reg == CharLf)
                        && (at_match || ok_match))
                        modem_next = 1'b1;
                    if (byte_count_reg >= CW'(2) && prev2_reg == CharDollar && gps_match)
                        gps_next = 1'b1;
                end
                if (printable)
                    print_count_next = print_count_reg + CW'(1);
                prev2_next      = prev_reg;
                prev_next       = in_byte_reg;
                byte_count_next = byte_count_reg + CW'(1);
                if (byte_count_next >= SampleLimit
                    || (in_end_reg && byte_count_next >= BurstLimit))
                begin
                    fire         = 1'b1;
                    decided_next = 1'b1;
                end
            end
        end
    end

    assign print_x4   = {print_count_next, 2'b00};
    assign count_x3   = {2'b00, byte_count_next} + {1'b0, byte_count_next, 1'b0};
    assign count_wide = {7'd0, byte_count_next};

    always_comb
    begin
        if (pair_next)
            class_next = ClassPair;
        else if (framing_next)
            class_next = ClassEndMrk;
        else if (gps_next)
            class_next = ClassGps;
        else if (modem_next)
            class_next = ClassModem;
        else if (print_x4 > count_x3)
            class_next = ClassText;
        else
            class_next = ClassBinary;
        hex_next       = (class_next == ClassPair || class_next == ClassEndMrk
                          || class_next == ClassBinary);
        count_out_next = count_wide[SampleWidth-1:0];
        if (fire)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            byte_count_reg  <= '0;
            print_count_reg <= '0;
            prev_reg        <= '0;
            prev2_reg       <= '0;
            first_end_reg   <= 1'b0;
            pair_reg        <= 1'b0;
            framing_reg     <= 1'b0;
            gps_reg         <= 1'b0;
            modem_reg       <= 1'b0;
            decided_reg     <= 1'b0;
        end
        else
        begin
            if (rx.ready)
                in_valid_reg <= rx.valid;
            out_valid_reg   <= out_valid_next;
            byte_count_reg  <= byte_count_next;
            print_count_reg <= print_count_next;
            prev_reg        <= prev_next;
            prev2_reg       <= prev2_next;
            first_end_reg   <= first_end_next;
            pair_reg        <= pair_next;
            framing_reg     <= framing_next;
            gps_reg         <= gps_next;
            modem_reg       <= modem_next;
            decided_reg     <= decided_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_req_reg  <= rx.req_type;
            in_byte_reg <= rx.data_byte;
            in_end_reg  <= rx.burst_end;
        end
        if (fire)
        begin
            class_reg     <= class_next;
            hex_reg       <= hex_next;
            count_out_reg <= count_out_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.protocol_class = class_reg;
    assign result.hex_display    = hex_reg;
    assign result.sample_count   = count_out_reg;

`ifndef SYNTHESIS
    a_result_only_when_decided: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> decided_reg)
        else $error("result pending without a decision");

    a_hex_matches_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> hex_reg == (class_reg == ClassPair || class_reg == ClassEndMrk
                                      || class_reg == ClassBinary))
        else $error("hex display flag disagrees with class");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= SampleLimit && print_count_reg <= byte_count_reg)
        else $error("byte counters out of range");

    a_silent_after_decision: assert property (@(posedge clk) disable iff (!rst_n)
        (decided_reg && !(advance && in_req_reg == ReqRestart)) |=> !fire)
        else $error("second decision without restart");
`endif

endmodule
